FILE: design/udpd_pkg.sv
// Shared types and constants for the UDP port demultiplexer table.
`default_nettype none

package udpd_pkg;

    localparam int SLOT_W = 4;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int LEN_W  = 16;

    localparam logic [1:0] FN_BIND     = 2'd0;
    localparam logic [1:0] FN_RELEASE  = 2'd1;
    localparam logic [1:0] FN_CLASSIFY = 2'd2;
    localparam logic [1:0] FN_NONE     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_NO_MATCH = 2'd3;

    localparam logic [PORT_W-1:0] EPH_FIRST = 16'd49152;
    localparam logic [PORT_W-1:0] EPH_LAST  = 16'hFFFF;
    localparam logic [LEN_W-1:0]  HDR_BYTES = 16'd8;

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] slot;
        logic [IP_W-1:0]   bind_ip;
        logic [PORT_W-1:0] bind_port;
        logic [IP_W-1:0]   dst_ip;
        logic [PORT_W-1:0] dst_port;
        logic [LEN_W-1:0]  buffer_len;
        logic [LEN_W-1:0]  header_len;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [PORT_W-1:0] assigned_port;
        logic [SLOT_W-1:0] match_slot;
        logic [LEN_W-1:0]  payload_len;
    } t_res;

    // request token walking the slot chain
    typedef struct packed {
        logic              valid;
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic              found;
        logic [SLOT_W-1:0] match;
    } t_tok;

endpackage

`default_nettype wire

FILE: design/udpd_cell.sv
// One socket slot of the demux chain: holds the binding and passes the token on.
`default_nettype none

module udpd_cell #(
    parameter int IDX = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire udpd_pkg::t_tok  i_tok,
    output udpd_pkg::t_tok       o_tok
);

    logic                         r_bound;
    logic [udpd_pkg::IP_W-1:0]    r_addr;
    logic [udpd_pkg::PORT_W-1:0]  r_port;
    udpd_pkg::t_tok               r_tok;
    udpd_pkg::t_tok               n_tok;
    logic                         w_sel;
    logic                         w_hit;

    assign w_sel = (IDX < (1 << udpd_pkg::SLOT_W)) &&
                   (i_tok.slot == udpd_pkg::SLOT_W'(IDX));
    assign w_hit = r_bound && (r_port == i_tok.port) &&
                   ((r_addr == '0) || (r_addr == i_tok.ip));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= 1'b0;
        end else if (i_tok.valid && w_sel) begin
            unique case (i_tok.op)
                udpd_pkg::FN_BIND:    r_bound <= 1'b1;
                udpd_pkg::FN_RELEASE: r_bound <= 1'b0;
                default:              r_bound <= r_bound;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid && w_sel) begin
            unique case (i_tok.op)
                udpd_pkg::FN_BIND: begin
                    r_addr <= i_tok.ip;
                    r_port <= i_tok.port;
                end
                udpd_pkg::FN_RELEASE: begin
                    r_addr <= '0;
                    r_port <= '0;
                end
                default: begin
                    r_addr <= r_addr;
                    r_port <= r_port;
                end
            endcase
        end
    end

    always_comb begin
        n_tok = i_tok;
        if ((i_tok.op == udpd_pkg::FN_CLASSIFY) && !i_tok.found && w_hit) begin
            n_tok.found = 1'b1;
            n_tok.match = udpd_pkg::SLOT_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.op    <= n_tok.op;
        r_tok.slot  <= n_tok.slot;
        r_tok.ip    <= n_tok.ip;
        r_tok.port  <= n_tok.port;
        r_tok.found <= n_tok.found;
        r_tok.match <= n_tok.match;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: design/udp_port_demux_table.sv
// Top level of the UDP port demultiplexer table: request entry, slot chain, result staging.
`default_nettype none

// Each request (bind, release or classify) enters a chain of SLOT_COUNT slot
// cells and moves one cell per clock; the lowest bound slot that matches the
// destination port and address claims a classify request. One request is in
// the slot chain at a time. Its result passes from the entry register through
// each cell to a staging register and then to the output register, which it
// enters only once the output is free.
// The next request is taken as soon as the previous result reaches the output
// register, even while that result still waits. Ephemeral ports start at
// 49152 and wrap back to 49152 after 65535.
module udp_port_demux_table #(
    parameter int SLOT_COUNT = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    output logic                 o_req_ready,
    input  wire udpd_pkg::t_req  i_req,
    output logic                 o_res_valid,
    input  wire                  i_res_ready,
    output udpd_pkg::t_res       o_res
);

    udpd_pkg::t_tok               w_tok [SLOT_COUNT+1];
    udpd_pkg::t_tok               r_tok;
    udpd_pkg::t_tok               n_tok;
    logic [SLOT_COUNT-1:0]        w_tok_v;

    logic                         r_busy;
    logic [udpd_pkg::PORT_W-1:0]  r_eph;
    logic [1:0]                   r_pre_status;
    logic [udpd_pkg::PORT_W-1:0]  r_assigned;
    logic [udpd_pkg::LEN_W-1:0]   r_payload;
    logic                         r_search;
    logic                         r_pend_v;
    udpd_pkg::t_res               r_pend;
    logic                         r_out_v;
    udpd_pkg::t_res               r_out;

    logic                         w_acc;
    logic                         w_slot_ok;
    logic                         w_take_eph;
    logic [udpd_pkg::PORT_W-1:0]  w_bport;
    logic [1:0]                   n_pre_status;
    logic                         w_len_ok;
    logic                         w_move;
    udpd_pkg::t_tok               w_exit;

    assign w_acc       = i_req_valid && o_req_ready;
    assign o_req_ready = !r_busy;
    assign w_slot_ok   = (32'(i_req.slot) < SLOT_COUNT);
    assign w_take_eph  = (i_req.func == udpd_pkg::FN_BIND) && w_slot_ok &&
                         (i_req.bind_port == '0);
    assign w_bport     = (i_req.bind_port == '0) ? r_eph : i_req.bind_port;

    always_comb begin
        n_pre_status = udpd_pkg::ST_OK;
        if (i_req.func == udpd_pkg::FN_CLASSIFY) begin
            if (i_req.buffer_len < udpd_pkg::HDR_BYTES) begin
                n_pre_status = udpd_pkg::ST_SHORT;
            end else if ((i_req.header_len < udpd_pkg::HDR_BYTES) ||
                         (i_req.header_len > i_req.buffer_len)) begin
                n_pre_status = udpd_pkg::ST_BAD_LEN;
            end
        end
    end

    assign w_len_ok = (n_pre_status == udpd_pkg::ST_OK);

    always_comb begin
        n_tok       = r_tok;
        n_tok.valid = w_acc;
        if (w_acc) begin
            n_tok.op    = i_req.func;
            n_tok.slot  = i_req.slot;
            n_tok.found = 1'b0;
            n_tok.match = '0;
            if (i_req.func == udpd_pkg::FN_CLASSIFY) begin
                n_tok.ip   = i_req.dst_ip;
                n_tok.port = i_req.dst_port;
                if (!w_len_ok) begin
                    n_tok.op = udpd_pkg::FN_NONE;
                end
            end else begin
                n_tok.ip   = i_req.bind_ip;
                n_tok.port = w_bport;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.op    <= n_tok.op;
        r_tok.slot  <= n_tok.slot;
        r_tok.ip    <= n_tok.ip;
        r_tok.port  <= n_tok.port;
        r_tok.found <= n_tok.found;
        r_tok.match <= n_tok.match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eph <= udpd_pkg::EPH_FIRST;
        end else if (w_acc && w_take_eph) begin
            r_eph <= (r_eph == udpd_pkg::EPH_LAST) ? udpd_pkg::EPH_FIRST
                                                  : r_eph + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pre_status <= n_pre_status;
            r_assigned   <= ((i_req.func == udpd_pkg::FN_BIND) && w_slot_ok) ?
                            w_bport : '0;
            r_payload    <= i_req.header_len - udpd_pkg::HDR_BYTES;
            r_search     <= (i_req.func == udpd_pkg::FN_CLASSIFY) && w_len_ok;
        end
    end

    assign w_tok[0] = r_tok;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        udpd_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
        assign w_tok_v[g] = w_tok[g+1].valid;
    end

    assign w_exit = w_tok[SLOT_COUNT];
    assign w_move = r_pend_v && (!r_out_v || i_res_ready);

    always_ff @(posedge i_clk) begin
        if (w_exit.valid) begin
            r_pend.assigned_port <= r_assigned;
            if (r_search) begin
                r_pend.status      <= w_exit.found ? udpd_pkg::ST_OK
                                                   : udpd_pkg::ST_NO_MATCH;
                r_pend.match_slot  <= w_exit.found ? w_exit.match : '0;
                r_pend.payload_len <= w_exit.found ? r_payload : '0;
            end else begin
                r_pend.status      <= r_pre_status;
                r_pend.match_slot  <= '0;
                r_pend.payload_len <= '0;
            end
        end
        if (w_move) begin
            r_out <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_exit.valid) begin
                r_pend_v <= 1'b1;
            end else if (w_move) begin
                r_pend_v <= 1'b0;
            end
            if (w_move) begin
                r_out_v <= 1'b1;
            end else if (i_res_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok_v, r_tok.valid}))
        else $error("more than one request in the slot chain");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tok.valid || w_exit.valid || r_pend_v) |-> r_busy)
        else $error("request in flight while table reports idle");

    a_eph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eph[15:14] == 2'b11)
        else $error("ephemeral counter left its range");

    a_exit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> !r_pend_v)
        else $error("chain result overwrites a staged result");

endmodule

`default_nettype wire
